// ===== rtl/core/dff_pkg.sv =====
`default_nettype none

package dff_pkg;

  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned BCD_DIGITS       = 10;
  localparam int unsigned BCD_W            = 4 * BCD_DIGITS;
  localparam int unsigned STEP_BITS        = 8;
  localparam int unsigned CONV_STAGES      = COUNT_W / STEP_BITS;
  localparam int unsigned CHAR_W           = 6;
  localparam int unsigned FIELD_DIGITS_DEF = 10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_SPACE = CHAR_W'(32);

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [COUNT_W-1:0] bin;
  } conv_t;

endpackage

`default_nettype wire

// ===== rtl/core/decimal_field_formatter_core.sv =====
// Decimal field formatter.
// Input channel: in_valid_i, in_stall_o and count_value_i, a 32-bit unsigned count.
// Output channel: out_valid_o, out_stall_i, text_char_o and last_char_o. Every
// input beat yields FIELD_DIGITS output beats: the decimal digits of the count in
// ASCII, most significant first without leading zeros, then ASCII spaces to fill
// the field. A count of zero gives a single '0'. last_char_o marks the final beat.
// When FIELD_DIGITS is below ten only the low FIELD_DIGITS decimal digits are kept.
// The conversion is a shift-and-add-3 pipeline of four stages of eight bits each,
// followed by a leading-digit stage, a serialiser and an output register.
// Throughput: one character per cycle while the output is not stalled, set by the
// serialiser, which takes the next count as it emits the final character of the
// last one. Up to seven counts can be in flight at once, one of them only as its
// final character waiting in the output register.
// A stall on the output holds the output register and, stage by stage, the
// pipeline behind it; nothing is lost or repeated, and in_stall_o rises once
// the pipeline is full. Reset clears all valid bits and the serialiser.
`default_nettype none

module decimal_field_formatter_core #(
  parameter int unsigned FIELD_DIGITS = dff_pkg::FIELD_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dff_pkg::COUNT_W-1:0]   count_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [dff_pkg::CHAR_W-1:0]         text_char_o,
  output logic                               last_char_o
);

  localparam int unsigned IDX_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1;

  dff_pkg::conv_t  conv  [dff_pkg::CONV_STAGES + 1];
  logic            valid [dff_pkg::CONV_STAGES + 1];
  logic            stall [dff_pkg::CONV_STAGES + 1];

  logic             lead_valid;
  logic             lead_stall;
  dff_pkg::digit_t  lead_dig [FIELD_DIGITS];
  logic [IDX_W-1:0] lead_top;

  assign conv[0]     = '{bcd: '0, bin: count_value_i};
  assign valid[0]    = in_valid_i;
  assign in_stall_o  = stall[0];

  for (genvar s = 0; s < dff_pkg::CONV_STAGES; s++) begin : g_stage
    dff_dabble_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[s]),
      .in_stall_o  (stall[s]),
      .data_i      (conv[s]),
      .out_valid_o (valid[s+1]),
      .out_stall_i (stall[s+1]),
      .data_o      (conv[s+1])
    );
  end

  dff_lead #(
    .FIELD_DIGITS (FIELD_DIGITS),
    .IDX_W        (IDX_W)
  ) u_lead (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid[dff_pkg::CONV_STAGES]),
    .in_stall_o  (stall[dff_pkg::CONV_STAGES]),
    .bcd_i       (conv[dff_pkg::CONV_STAGES].bcd),
    .out_valid_o (lead_valid),
    .out_stall_i (lead_stall),
    .dig_o       (lead_dig),
    .top_o       (lead_top)
  );

  dff_serializer #(
    .FIELD_DIGITS (FIELD_DIGITS),
    .IDX_W        (IDX_W)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lead_valid),
    .in_stall_o  (lead_stall),
    .dig_i       (lead_dig),
    .top_i       (lead_top),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dff_dabble_stage.sv =====
`default_nettype none

module dff_dabble_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dff_pkg::conv_t data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dff_pkg::conv_t     data_o
);

  localparam int unsigned ACC_W = dff_pkg::BCD_W + dff_pkg::COUNT_W;

  logic           valid_q;
  logic           load;
  dff_pkg::conv_t data_d;
  dff_pkg::conv_t data_q;

  always_comb begin
    logic [ACC_W-1:0] acc;
    acc = {data_i.bcd, data_i.bin};
    for (int s = 0; s < int'(dff_pkg::STEP_BITS); s++) begin
      for (int d = 0; d < int'(dff_pkg::BCD_DIGITS); d++) begin
        if (acc[dff_pkg::COUNT_W + 4 * d +: 4] >= 4'd5) begin
          acc[dff_pkg::COUNT_W + 4 * d +: 4] = acc[dff_pkg::COUNT_W + 4 * d +: 4] + 4'd3;
        end
      end
      acc = {acc[ACC_W-2:0], 1'b0};
    end
    data_d.bcd = acc[ACC_W-1:dff_pkg::COUNT_W];
    data_d.bin = acc[dff_pkg::COUNT_W-1:0];
  end

  assign in_stall_o = valid_q && out_stall_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/dff_lead.sv =====
`default_nettype none

module dff_lead #(
  parameter int unsigned FIELD_DIGITS = dff_pkg::FIELD_DIGITS_DEF,
  parameter int unsigned IDX_W        = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [dff_pkg::BCD_W-1:0] bcd_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output dff_pkg::digit_t              dig_o [FIELD_DIGITS],
  output logic [IDX_W-1:0]             top_o
);

  logic            valid_q;
  logic            load;
  dff_pkg::digit_t dig_d [FIELD_DIGITS];
  dff_pkg::digit_t dig_q [FIELD_DIGITS];
  logic [IDX_W-1:0] top_d;
  logic [IDX_W-1:0] top_q;

  for (genvar i = 0; i < FIELD_DIGITS; i++) begin : g_dig
    if (i < dff_pkg::BCD_DIGITS) begin : g_real
      assign dig_d[i] = bcd_i[4 * i +: 4];
    end else begin : g_pad
      assign dig_d[i] = 4'd0;
    end
  end

  always_comb begin
    top_d = '0;
    for (int i = 0; i < int'(FIELD_DIGITS); i++) begin
      if (dig_d[i] != 4'd0) begin
        top_d = IDX_W'(i);
      end
    end
  end

  assign in_stall_o = valid_q && out_stall_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      dig_q <= dig_d;
      top_q <= top_d;
    end
  end

  assign out_valid_o = valid_q;
  assign dig_o       = dig_q;
  assign top_o       = top_q;

endmodule

`default_nettype wire

// ===== rtl/core/dff_serializer.sv =====
`default_nettype none

module dff_serializer #(
  parameter int unsigned FIELD_DIGITS = dff_pkg::FIELD_DIGITS_DEF,
  parameter int unsigned IDX_W        = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire dff_pkg::digit_t           dig_i [FIELD_DIGITS],
  input  wire logic [IDX_W-1:0]          top_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [dff_pkg::CHAR_W-1:0]     text_char_o,
  output logic                           last_char_o
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(FIELD_DIGITS - 1);

  logic             busy_q;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] top_q;
  dff_pkg::digit_t  dig_q [FIELD_DIGITS];

  logic                        out_valid_q;
  logic [dff_pkg::CHAR_W-1:0]  char_q;
  logic                        last_q;

  logic                        out_free;
  logic                        emit;
  logic                        done;
  logic                        load;
  logic [dff_pkg::CHAR_W-1:0]  char_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = busy_q && out_free;
  assign done       = emit && (k_q == LAST);
  assign in_stall_o = busy_q && !done;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (k_q <= top_q) begin
      char_d = dff_pkg::ASCII_ZERO + {2'b00, dig_q[top_q - k_q]};
    end else begin
      char_d = dff_pkg::ASCII_SPACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        k_q <= IDX_W'(k_q + 1'b1);
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= dig_i;
      top_q <= top_i;
    end
    if (emit) begin
      char_q <= char_d;
      last_q <= (k_q == LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire
